// File: rtl/fltw_pkg.sv
// Shared types and constants for the four-level page table walker.
`timescale 1ns / 1ps
package fltw_pkg;
	localparam int MEM_WORDS = 4096;
	localparam int AW = $clog2(MEM_WORDS);

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_XLATE  = 2'd1;
	localparam logic [1:0] KIND_UNMAP  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_UNMAPPED   = 2'd1;
	localparam logic [1:0] ST_MISALIGNED = 2'd2;
	localparam logic [1:0] ST_RANGE      = 2'd3;

	localparam logic [1:0] PS_NONE = 2'd0;
	localparam logic [1:0] PS_4K   = 2'd1;
	localparam logic [1:0] PS_2M   = 2'd2;
	localparam logic [1:0] PS_1G   = 2'd3;

	// Classified command handed from front to back
	typedef struct packed {
		logic [1:0]  kind;
		logic        early;      // answered without a walk
		logic [1:0]  early_st;
		logic [AW:0] widx;       // write address plus out-of-range flag in msb
		logic [63:0] wdata;
		logic [47:0] va;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);
endpackage

// File: rtl/fltw_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module fltw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: rtl/fltw_front.sv
// Front end: accepts input beats, classifies them and queues commands.
`timescale 1ns / 1ps
module fltw_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               kind,
	input  logic [11:0]              word_index,
	input  logic [63:0]              write_data,
	input  logic [63:0]              vaddr,
	output logic                     cmd_valid,
	output fltw_pkg::cmd_t           cmd,
	input  logic                     cmd_take
);
	fltw_pkg::cmd_t q_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	fltw_pkg::cmd_t c;

	// Classify the incoming beat
	always_comb begin
		c = '0;
		c.kind  = kind;
		c.wdata = write_data;
		c.va    = vaddr[47:0];
		c.widx  = {1'b0, word_index[fltw_pkg::AW-1:0]};
		if (32'(word_index) >= 32'(fltw_pkg::MEM_WORDS)) c.widx[fltw_pkg::AW] = 1'b1;
		c.early = 1'b0;
		c.early_st = fltw_pkg::ST_OK;
		if (kind == fltw_pkg::KIND_UNMAP && vaddr[11:0] != 12'd0) begin
			c.early = 1'b1;
			c.early_st = fltw_pkg::ST_MISALIGNED;
		end else if (kind != fltw_pkg::KIND_XLATE && kind != fltw_pkg::KIND_UNMAP
				&& kind != fltw_pkg::KIND_WRITE) begin
			c.early = 1'b1;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	// Two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				q_q[wp_q] <= c;
				wp_q <= ~wp_q;
			end
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cmd_take);
		end
	end
endmodule

// File: rtl/fltw_back.sv
// Back end: runs table writes and walks, clears memory after reset, holds results.
`timescale 1ns / 1ps
module fltw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     root_frame,
	input  logic           cmd_valid,
	input  fltw_pkg::cmd_t cmd,
	output logic           cmd_take,
	output logic           busy,
	output logic           empty,
	input  logic           pop,
	output logic [51:0]    xlat_addr,
	output logic [1:0]     status,
	output logic [1:0]     map_size
);
	localparam int AW = fltw_pkg::AW;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DONE} state_t;

	state_t         state_q;
	fltw_pkg::cmd_t cur_q;
	logic [1:0]     lvl_q;
	logic [AW:0]    clr_q;
	logic [AW-1:0]  addr_q;
	logic [51:0]    res_pa_q;
	logic [1:0]     res_st_q, res_ps_q;
	logic           res_v_q;

	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [63:0]    ram_wdata, e;
	logic [39:0]    nfr;
	logic [8:0]     idx;
	logic [48:0]    waddr;

	fltw_ram #(.WIDTH(64), .DEPTH(fltw_pkg::MEM_WORDS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(e));

	assign empty     = !res_v_q;
	assign xlat_addr = res_pa_q;
	assign status    = res_st_q;
	assign map_size  = res_ps_q;
	assign busy      = (state_q != S_IDLE) || cmd_valid || res_v_q;
	assign cmd_take  = (state_q == S_IDLE) && cmd_valid && !res_v_q;
	assign nfr       = e[51:12];

	// Index into the table of the next level
	always_comb begin
		case (lvl_q)
			2'd0: idx = cur_q.va[38:30];
			2'd1: idx = cur_q.va[29:21];
			2'd2: idx = cur_q.va[20:12];
			default: idx = cur_q.va[47:39];
		endcase
	end
	assign waddr = {nfr, idx};

	// Memory port selection
	always_comb begin
		ram_we = 1'b0;
		ram_addr = addr_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
			ram_addr = clr_q[AW-1:0];
		end else if (cmd_take && cmd.kind == fltw_pkg::KIND_WRITE && !cmd.widx[AW]) begin
			ram_we = 1'b1;
			ram_addr = cmd.widx[AW-1:0];
			ram_wdata = cmd.wdata;
		end else if (state_q == S_CHECK && lvl_q == 2'd3
				&& cur_q.kind == fltw_pkg::KIND_UNMAP) begin
			ram_we = 1'b1;
		end
	end

	// Walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			res_v_q <= 1'b0;
			lvl_q <= '0;
		end else begin
			if (pop && res_v_q) res_v_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(fltw_pkg::MEM_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_take) begin
						cur_q <= cmd;
						res_pa_q <= '0;
						res_ps_q <= fltw_pkg::PS_NONE;
						res_st_q <= cmd.early_st;
						lvl_q <= 2'd0;
						if (cmd.early || cmd.kind == fltw_pkg::KIND_WRITE) begin
							res_v_q <= 1'b1;
						end else if (32'({root_frame, cmd.va[47:39]})
								>= 32'(fltw_pkg::MEM_WORDS)) begin
							res_st_q <= fltw_pkg::ST_RANGE;
							res_v_q <= 1'b1;
						end else begin
							addr_q <= AW'({root_frame, cmd.va[47:39]});
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					state_q <= S_DONE;
					if (lvl_q == 2'd3) begin
						if (cur_q.kind == fltw_pkg::KIND_UNMAP) begin
							// leaf cleared by the port write this cycle
						end else if (!e[0]) begin
							res_st_q <= fltw_pkg::ST_UNMAPPED;
						end else begin
							res_pa_q <= {e[51:12], cur_q.va[11:0]};
							res_ps_q <= fltw_pkg::PS_4K;
						end
					end else if (!e[0]) begin
						res_st_q <= fltw_pkg::ST_UNMAPPED;
					end else if (e[7] && lvl_q != 2'd0) begin
						if (cur_q.kind == fltw_pkg::KIND_UNMAP) begin
							res_st_q <= fltw_pkg::ST_UNMAPPED;
						end else if (lvl_q == 2'd1) begin
							res_pa_q <= {e[51:30], cur_q.va[29:0]};
							res_ps_q <= fltw_pkg::PS_1G;
						end else begin
							res_pa_q <= {e[51:21], cur_q.va[20:0]};
							res_ps_q <= fltw_pkg::PS_2M;
						end
					end else if (waddr >= 49'(fltw_pkg::MEM_WORDS)) begin
						res_st_q <= fltw_pkg::ST_RANGE;
					end else begin
						addr_q <= waddr[AW-1:0];
						lvl_q <= lvl_q + 2'd1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					res_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker.
//   channel  | signals                                    | beat when
//   input    | push full kind word_index write_data vaddr | push && !full
//   result   | empty pop xlat_addr status map_size        | pop && !empty
//   config   | psel penable pwrite paddr pwdata prdata    | psel&penable&pwrite
// A write item needs no walk; a walk reads one entry per level, up to four,
// in states S_READ and S_CHECK, through the single table memory port.
// After reset the back end clears all 4096 memory words before taking items.
// A two-entry queue sits between front and back; a held result stalls the back,
// and the input once the queue has filled.
`timescale 1ns / 1ps
module four_level_page_table_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [11:0] word_index,
	input  logic [63:0] write_data,
	input  logic [63:0] vaddr,
	output logic        empty,
	input  logic        pop,
	output logic [51:0] xlat_addr,
	output logic [1:0]  status,
	output logic [1:0]  map_size,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic           cmd_valid, cmd_take, busy;
	fltw_pkg::cmd_t cmd;
	logic [2:0]     root_q;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {29'd0, root_q} : 32'd0;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_q <= '0;
		else if (psel && penable && pwrite && paddr == 1'b0) root_q <= pwdata[2:0];
	end

	fltw_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.word_index(word_index), .write_data(write_data), .vaddr(vaddr),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take));

	fltw_back u_back (
		.clk(clk), .arst_n(arst_n), .root_frame(root_q), .cmd_valid(cmd_valid),
		.cmd(cmd), .cmd_take(cmd_take), .busy(busy), .empty(empty), .pop(pop),
		.xlat_addr(xlat_addr), .status(status), .map_size(map_size));

	// Translation results only carry a page size when ok
	a_ps_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && map_size != fltw_pkg::PS_NONE) |-> status == fltw_pkg::ST_OK)
		else $error("page size on failed result");
	a_pa_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && map_size == fltw_pkg::PS_NONE) |-> xlat_addr == 52'd0)
		else $error("address without page");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid && busy)
		else $error("command taken from empty queue");
endmodule
